>>> sv/i2cmbe_pkg.sv
// i2cmbe_pkg: shared types and constants for the i2c master bit engine
// holds command codes, register indexes, reset values and item layouts
// no dependencies
`default_nettype none

package i2cmbe_pkg;

	localparam int unsigned MODE_W   = 3;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE  = 3'd0,
		MODE_START = 3'd1,
		MODE_STOP  = 3'd2,
		MODE_WRITE = 3'd3,
		MODE_READ  = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_PERIOD  = 3'd0,
		REG_HOLD_TIME    = 3'd1,
		REG_SAMPLE_DELAY = 3'd2,
		REG_ACK_TIMEOUT  = 3'd3
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] HALF_PERIOD_RST  = 8'd2;
	localparam logic [BYTE_W-1:0] HOLD_TIME_RST    = 8'd4;
	localparam logic [BYTE_W-1:0] SAMPLE_DELAY_RST = 8'd1;
	localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST  = 8'd200;
	localparam logic [BYTE_W-1:0] MSB_MASK         = 8'h80;
	localparam logic [3:0]        BITS_PER_BYTE    = 4'd8;

	// input item, highest bit first
	typedef struct packed {
		logic [2:0]        pad;
		logic              sda_in;
		logic              send_ack;
		logic [BYTE_W-1:0] tx_byte;
		logic [MODE_W-1:0] mode;
	} in_item_t;

	// result item, highest bit first
	typedef struct packed {
		logic              pad;
		logic              timed_out;
		logic              ack_seen;
		logic [BYTE_W-1:0] rx_byte;
		logic              done_res;
		logic              busy_res;
		logic              sda_drive;
		logic              sda_out;
		logic              scl;
	} out_item_t;

endpackage

`default_nettype wire

>>> sv/i2c_master_bit_engine.sv
// i2c_master_bit_engine: pin-level i2c master, one item per bus tick
// depends on i2cmbe_pkg
//
// usage:
//   s_axis carries one tick per item: command (none, start, stop, write,
//   read), the byte to write, the ack choice for a read and the sampled sda.
//   m_axis returns one result per tick: scl, sda level, sda direction, busy,
//   a done pulse, the last read byte and the ack/timeout status of the
//   last write.
//   cfg carries register writes (index, 8-bit data); always ready. Write
//   only while no command is in progress.
// latency and throughput:
//   each tick is worked out in the cycle it is accepted and its result is
//   valid on m_axis the next cycle. One tick per clock is sustained while m_axis_tready is high; the
//   only storage on the path is the phase state and the result register.
// reset:
//   phase idle, counters cleared, pins scl high / sda high driven, status
//   zero, timing registers at their default values.
// stall:
//   while a result waits with m_axis_tready low, s_axis_tready stays low
//   unless the result is taken in the same cycle; no tick is lost.
`default_nettype none

module i2c_master_bit_engine
	import i2cmbe_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// mode[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero fill
	input  wire logic [15:0]          s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
	// rx_byte[12:5], ack_seen[13], timed_out[14], zero fill
	output logic [15:0]               m_axis_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_S1, PH_S2, PH_S3, PH_P1, PH_P2,
		PH_WLO, PH_WHI, PH_WLO2, PH_WREL, PH_WPOLL, PH_WEND,
		PH_RLO, PH_RHI, PH_ALO, PH_AHI, PH_AEND
	} phase_t;

	logic [BYTE_W-1:0] half_period_q, hold_time_q, sample_delay_q, ack_timeout_q;
	phase_t            phase_q;
	logic [3:0]        bit_count_q;
	logic [BYTE_W-1:0] shift_q, wait_q, poll_q;
	logic              ack_choice_q;
	logic              pin_scl_q, pin_sda_q, pin_drv_q;
	logic [BYTE_W-1:0] rx_byte_q;
	logic              ack_seen_q, timed_out_q;
	logic              out_valid_q;
	out_item_t         out_q;

	in_item_t  in_item;
	logic      accept;

	phase_t            ph_d;
	logic [3:0]        bc_d;
	logic [BYTE_W-1:0] sr_d, wc_d, pc_d, rx_d;
	logic              ack_d, scl_d, sda_d, drv_d, seen_d, tout_d, done_d;
	logic [BYTE_W-1:0] len;
	logic [BYTE_W:0]   wc_inc;
	logic [3:0]        bc_inc;
	logic [BYTE_W-1:0] pc_inc;
	logic              end_ph;

	assign in_item       = in_item_t'(s_axis_tdata);
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = 16'(out_q);

	function automatic logic [BYTE_W-1:0] at_least_one(input logic [BYTE_W-1:0] v);
		return (v == '0) ? BYTE_W'(1) : v;
	endfunction

	always_comb begin
		ph_d   = phase_q;
		bc_d   = bit_count_q;
		sr_d   = shift_q;
		wc_d   = wait_q;
		pc_d   = poll_q;
		ack_d  = ack_choice_q;
		scl_d  = pin_scl_q;
		sda_d  = pin_sda_q;
		drv_d  = pin_drv_q;
		rx_d   = rx_byte_q;
		seen_d = ack_seen_q;
		tout_d = timed_out_q;
		done_d = 1'b0;
		len    = at_least_one(half_period_q);
		wc_inc = '0;
		bc_inc = '0;
		pc_inc = '0;
		end_ph = 1'b0;

		// a command taken while idle counts as the first tick of its first phase
		if (phase_q == PH_IDLE) begin
			case (in_item.mode)
				MODE_START: begin
					ph_d = PH_S1; bc_d = '0; pc_d = '0; wc_d = '0;
				end
				MODE_STOP: begin
					ph_d = PH_P1; bc_d = '0; pc_d = '0; wc_d = '0;
				end
				MODE_WRITE: begin
					ph_d = PH_WLO; bc_d = '0; pc_d = '0; wc_d = '0;
					sr_d = in_item.tx_byte;
				end
				MODE_READ: begin
					ph_d = PH_RLO; bc_d = '0; pc_d = '0; wc_d = '0;
					sr_d = '0;
					ack_d = in_item.send_ack;
				end
				default: ;
			endcase
		end

		if (ph_d != PH_IDLE) begin
			case (ph_d)
				PH_S1, PH_P2:            begin scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1; end
				PH_S2:                   begin scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1; end
				PH_S3, PH_P1:            begin scl_d = 1'b0; sda_d = 1'b0; drv_d = 1'b1; end
				PH_WLO, PH_WLO2: begin
					scl_d = 1'b0; sda_d = |(sr_d & MSB_MASK); drv_d = 1'b1;
				end
				PH_WHI: begin
					scl_d = 1'b1; sda_d = |(sr_d & MSB_MASK); drv_d = 1'b1;
				end
				PH_WREL, PH_WEND, PH_RLO: begin scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b0; end
				PH_WPOLL, PH_RHI:        begin scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b0; end
				PH_ALO, PH_AEND:         begin scl_d = 1'b0; sda_d = !ack_d; drv_d = 1'b1; end
				PH_AHI:                  begin scl_d = 1'b1; sda_d = !ack_d; drv_d = 1'b1; end
				default: ;
			endcase

			case (ph_d)
				PH_S1, PH_S2, PH_P1, PH_P2: len = at_least_one(hold_time_q);
				PH_RHI:                     len = at_least_one(sample_delay_q);
				PH_S3, PH_AEND:             len = BYTE_W'(1);
				default:                    len = at_least_one(half_period_q);
			endcase

			bc_inc = bc_d + 4'd1;
			pc_inc = pc_d + BYTE_W'(1);
			wc_inc = {1'b0, wc_d} + (BYTE_W+1)'(1);

			if (ph_d == PH_WPOLL) begin
				if (!in_item.sda_in) begin
					seen_d = 1'b1; tout_d = 1'b0;
					ph_d = PH_WEND; wc_d = '0;
				end else begin
					pc_d = pc_inc;
					if (pc_inc >= ack_timeout_q) begin
						seen_d = 1'b0; tout_d = 1'b1;
						ph_d = PH_WEND; wc_d = '0;
					end
				end
			end else begin
				// read bit is sampled on the first tick of scl high
				if (ph_d == PH_RHI && wc_d == '0)
					sr_d = {sr_d[BYTE_W-2:0], in_item.sda_in};
				end_ph = (wc_inc >= {1'b0, len});
				if (end_ph) begin
					wc_d = '0;
					case (ph_d)
						PH_S1:   ph_d = PH_S2;
						PH_S2:   ph_d = PH_S3;
						PH_P1:   ph_d = PH_P2;
						PH_WLO:  ph_d = PH_WHI;
						PH_WHI:  ph_d = PH_WLO2;
						PH_WLO2: begin
							sr_d = {sr_d[BYTE_W-2:0], 1'b0};
							bc_d = bc_inc;
							if (bc_inc >= BITS_PER_BYTE) begin
								pc_d = '0;
								ph_d = PH_WREL;
							end else begin
								ph_d = PH_WLO;
							end
						end
						PH_WREL: ph_d = PH_WPOLL;
						PH_RLO:  ph_d = PH_RHI;
						PH_RHI: begin
							bc_d = bc_inc;
							ph_d = (bc_inc >= BITS_PER_BYTE) ? PH_ALO : PH_RLO;
						end
						PH_ALO:  ph_d = PH_AHI;
						PH_AHI:  ph_d = PH_AEND;
						PH_AEND: begin
							rx_d = sr_d;
							ph_d = PH_IDLE; done_d = 1'b1;
						end
						default: begin
							ph_d = PH_IDLE; done_d = 1'b1;
						end
					endcase
				end else begin
					wc_d = wc_inc[BYTE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q  <= HALF_PERIOD_RST;
			hold_time_q    <= HOLD_TIME_RST;
			sample_delay_q <= SAMPLE_DELAY_RST;
			ack_timeout_q  <= ACK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_PERIOD:  half_period_q  <= cfg_data;
				REG_HOLD_TIME:    hold_time_q    <= cfg_data;
				REG_SAMPLE_DELAY: sample_delay_q <= cfg_data;
				REG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			shift_q      <= '0;
			wait_q       <= '0;
			poll_q       <= '0;
			ack_choice_q <= 1'b0;
			pin_scl_q    <= 1'b1;
			pin_sda_q    <= 1'b1;
			pin_drv_q    <= 1'b1;
			rx_byte_q    <= '0;
			ack_seen_q   <= 1'b0;
			timed_out_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				phase_q      <= ph_d;
				bit_count_q  <= bc_d;
				shift_q      <= sr_d;
				wait_q       <= wc_d;
				poll_q       <= pc_d;
				ack_choice_q <= ack_d;
				pin_scl_q    <= scl_d;
				pin_sda_q    <= sda_d;
				pin_drv_q    <= drv_d;
				rx_byte_q    <= rx_d;
				ack_seen_q   <= seen_d;
				timed_out_q  <= tout_d;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.pad       <= 1'b0;
			out_q.scl       <= scl_d;
			out_q.sda_out   <= sda_d;
			out_q.sda_drive <= drv_d;
			out_q.busy_res  <= (ph_d != PH_IDLE);
			out_q.done_res  <= done_d;
			out_q.rx_byte   <= rx_d;
			out_q.ack_seen  <= seen_d;
			out_q.timed_out <= tout_d;
		end
	end

	a_released_sda_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.sda_drive) |-> out_q.sda_out)
		else $error("released sda not reported high");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_res) |-> !out_q.busy_res)
		else $error("done pulse while still busy");

	a_status_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ack_seen_q && timed_out_q))
		else $error("ack and timeout both set");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	a_busy_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_q.busy_res == (phase_q != PH_IDLE)))
		else $error("busy flag disagrees with phase");

endmodule

`default_nettype wire
